// ===== design/button_debounce_long_press_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BDLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce package
// Field widths, action codes, register indexes and the result beat type.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int BTN_W   = 3;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int MAX_BTN = 1 << BTN_W;

	// Result queue depth; one item may push two beats.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_SHORT   = 2'd2,
		ACT_LONG    = 2'd3
	} action_t;

	typedef enum logic {
		CFG_DEBOUNCE   = 1'b0,
		CFG_LONG_PRESS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [BTN_W-1:0] event_button;
		action_t          action;
		logic             last_event;
	} result_t;

endpackage

// ===== design/bdlp_sample_if.sv =====
// ----------------------------------------------------------------------------
// Button sample channel
// Valid/ready channel that carries one raw button sample per beat.
// ----------------------------------------------------------------------------
interface bdlp_sample_if;

	logic        valid;
	logic        ready;
	logic [2:0]  button_index;
	logic        raw_level;
	logic [31:0] now_ms;

	modport source (output valid, output button_index, output raw_level,
		output now_ms, input ready);
	modport sink (input valid, input button_index, input raw_level,
		input now_ms, output ready);

endinterface

// ===== design/bdlp_result_if.sv =====
// ----------------------------------------------------------------------------
// Button event channel
// Valid/ready channel that carries one button event per beat.
// ----------------------------------------------------------------------------
interface bdlp_result_if;

	logic       valid;
	logic       ready;
	logic [2:0] event_button;
	logic [1:0] action;
	logic       last_event;

	modport source (output valid, output event_button, output action,
		output last_event, input ready);
	modport sink (input valid, input event_button, input action,
		input last_event, output ready);

endinterface

// ===== design/button_debounce_long_press_unit.sv =====
// ----------------------------------------------------------------------------
// Button debounce with long-press classification
// Per-button debounce on timestamped raw samples, emitting press, release
// and short or long press events.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake     beat contents
//   sample    in   valid/ready   button_index, raw_level, now_ms
//   result    out  valid/ready   event_button, action, last_event
//   cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
// A sample is captured in the input register and processed from there;
// a new sample is taken every cycle while the result queue has room for two.
// A press yields one beat and a release two, and the result port drains one
// beat per cycle while ready is high, so a steady run of releases fills the queue and stalls the input.
// Reset clears all per-button state at once; no clearing sweep is needed.
// A stalled result port backs up into the queue, then the input register.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_unit_defines.svh"

module button_debounce_long_press_unit #(
	parameter int NUM_BUTTONS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  bdlp_pkg::cfg_index_t          cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]    cfg_data,
	bdlp_sample_if.sink                   sample,
	bdlp_result_if.source                 result
);

	import bdlp_pkg::*;

	// The index field is three bits wide, so only the first eight buttons
	// can ever be addressed; storage is sized to what is reachable.
	localparam int DEPTH = (NUM_BUTTONS < MAX_BTN) ? NUM_BUTTONS : MAX_BTN;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [BTN_W:0] BTN_LIMIT = (BTN_W+1)'(DEPTH);

	// Configuration registers.
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= CFG_W'(20);
			long_press_q <= CFG_W'(300);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: holds the sample being processed this cycle.
	logic              valid_s1;
	logic [BTN_W-1:0]  btn_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;

	// Result queue.
	result_t              res_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_CNT_W-1:0] count_q;

	logic fire_s1;
	logic pop;

	// The item is processed only when two result slots are free, so a
	// release can always push both of its beats at once.
	assign fire_s1      = valid_s1 && (count_q <= RES_CNT_W'(RES_DEPTH - 2));
	assign sample.ready = !valid_s1 || fire_s1;
	assign pop          = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			btn_s1 <= sample.button_index;
			raw_s1 <= sample.raw_level;
			now_s1 <= sample.now_ms;
		end
	end

	// Per-button state.
	logic              last_raw_q    [DEPTH];
	logic [TIME_W-1:0] change_time_q [DEPTH];
	logic              stable_q      [DEPTH];
	logic [TIME_W-1:0] press_start_q [DEPTH];

	logic              in_range;
	logic [IDX_W-1:0]  idx;
	logic              raw_changed;
	logic [TIME_W-1:0] change_time_nx;
	logic [TIME_W-1:0] held_time;
	logic [TIME_W-1:0] press_time;
	logic              stable_change;
	logic              is_long;
	logic              upd;
	logic              push_one;
	logic              push_two;

	always_comb begin
		in_range = {1'b0, btn_s1} < BTN_LIMIT;
		// Out-of-range samples point at entry zero but never write it.
		idx = in_range ? btn_s1[IDX_W-1:0] : '0;
		raw_changed    = raw_s1 != last_raw_q[idx];
		change_time_nx = raw_changed ? now_s1 : change_time_q[idx];
		held_time      = now_s1 - change_time_nx;
		press_time     = now_s1 - press_start_q[idx];
		stable_change  = in_range && (held_time >= {16'd0, debounce_q})
			&& (raw_s1 != stable_q[idx]);
		is_long  = press_time >= {16'd0, long_press_q};
		upd      = fire_s1 && in_range;
		push_one = fire_s1 && stable_change && raw_s1;
		push_two = fire_s1 && stable_change && !raw_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				last_raw_q[i]    <= 1'b0;
				change_time_q[i] <= '0;
				stable_q[i]      <= 1'b0;
				press_start_q[i] <= '0;
			end
		end else if (upd) begin
			last_raw_q[idx]    <= raw_s1;
			change_time_q[idx] <= change_time_nx;
			if (stable_change) begin
				stable_q[idx] <= raw_s1;
				if (raw_s1) begin
					press_start_q[idx] <= now_s1;
				end
			end
		end
	end

	// Queue writes: a press pushes one beat, a release pushes the release
	// beat followed by its short or long classification.
	result_t beat_a;
	result_t beat_b;

	always_comb begin
		beat_a.event_button = btn_s1;
		beat_a.action       = raw_s1 ? ACT_PRESS : ACT_RELEASE;
		beat_a.last_event   = raw_s1;
		beat_b.event_button = btn_s1;
		beat_b.action       = is_long ? ACT_LONG : ACT_SHORT;
		beat_b.last_event   = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (push_one || push_two) begin
			res_q[wr_ptr_q] <= beat_a;
		end
		if (push_two) begin
			res_q[wr_ptr_q + RES_PTR_W'(1)] <= beat_b;
		end
	end

	logic [RES_CNT_W-1:0] push_cnt;

	always_comb begin
		push_cnt = push_two ? RES_CNT_W'(2) : (push_one ? RES_CNT_W'(1) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[RES_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + push_cnt - (pop ? RES_CNT_W'(1) : '0);
		end
	end

	result_t head;

	assign head                = res_q[rd_ptr_q];
	assign result.valid        = count_q != '0;
	assign result.event_button = head.event_button;
	assign result.action       = head.action;
	assign result.last_event   = head.last_event;

	// Assertions.
	`BDLP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= RES_CNT_W'(RES_DEPTH),
		"result queue overfilled")
	`BDLP_ASSERT_NOW(a_release_pair, result.valid && head.action == ACT_RELEASE,
		count_q >= RES_CNT_W'(2), "release beat without its classification queued")
	`BDLP_ASSERT_NEXT(a_s1_hold, valid_s1 && !fire_s1,
		valid_s1 && $stable(btn_s1) && $stable(raw_s1) && $stable(now_s1),
		"stalled sample lost from input register")
	`BDLP_ASSERT_NEXT(a_push_count, push_two,
		count_q == $past(count_q) + RES_CNT_W'(2) - ($past(pop) ? RES_CNT_W'(1) : '0),
		"release did not queue two beats")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce with long-press classification: testbench
// Drives timestamped raw button samples into the unit and checks every event
// beat against an in-bench model of the per-button debounce and press-length
// logic. Directed sequences cover the corners. Random bounce-and-settle
// sequences, mixed with noise, then run under several debounce and long-press
// settings and several handshake pressure profiles.
// ----------------------------------------------------------------------------
module tb;

	import bdlp_pkg::*;

	localparam int NUM_BUTTONS = 8;
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	// Cycles to let pass after the last expected beat before touching registers.
	localparam int SETTLE_CYCLES = 8;
	// Cycles with work outstanding and no beat moving on either side.
	localparam int STALL_LIMIT = 2000;
	localparam logic [CFG_W-1:0] DEBOUNCE_AT_RESET = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_AT_RESET = 16'd300;
	localparam logic [CFG_W-1:0] CFG_MAX = 16'hFFFF;

	typedef struct packed {
		logic [BTN_W-1:0]  btn;
		logic              raw;
		logic [TIME_W-1:0] stamp;
	} sample_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Configuration port, owned by the sequencing initial block.
	logic             cfg_we = 1'b0;
	cfg_index_t       cfg_index = CFG_DEBOUNCE;
	logic [CFG_W-1:0] cfg_data = '0;

	// Sample side, owned by the driver; known from time zero.
	logic              snd_valid = 1'b0;
	logic [BTN_W-1:0]  snd_btn = '0;
	logic              snd_raw = 1'b0;
	logic [TIME_W-1:0] snd_stamp = '0;

	// Event side ready, owned by the monitor.
	logic rcv_ready = 1'b0;

	bdlp_sample_if sample_ch();
	bdlp_result_if result_ch();

	assign sample_ch.valid = snd_valid;
	assign sample_ch.button_index = snd_btn;
	assign sample_ch.raw_level = snd_raw;
	assign sample_ch.now_ms = snd_stamp;
	assign result_ch.ready = rcv_ready;

	button_debounce_long_press_unit #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Debounce model. It mirrors the per-button state of the unit and the two
	// thresholds; the thresholds change only while the unit is idle, so the
	// model can apply each sample at the edge where it is accepted.
	// ------------------------------------------------------------------------
	logic              raw_seen [NUM_BUTTONS] = '{default: 1'b0};
	logic [TIME_W-1:0] raw_since [NUM_BUTTONS] = '{default: '0};
	logic              level_held [NUM_BUTTONS] = '{default: 1'b0};
	logic [TIME_W-1:0] press_began [NUM_BUTTONS] = '{default: '0};
	logic [CFG_W-1:0]  hold_ms = DEBOUNCE_AT_RESET;
	logic [CFG_W-1:0]  long_ms = LONG_PRESS_AT_RESET;

	result_t      expected_events [$];
	sample_beat_t pending_samples [$];

	// Samples queued but not yet accepted by the unit.
	int outstanding = 0;
	int unsigned mismatches = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	task automatic predict_events(input logic [BTN_W-1:0] btn, input logic raw,
		input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] held_for;
		logic [TIME_W-1:0] pressed_for;
		result_t ev;
		// Indexes past the configured button count leave everything alone.
		if (int'(btn) >= NUM_BUTTONS)
			return;
		// Any raw edge restarts the debounce window.
		if (raw != raw_seen[btn]) begin
			raw_seen[btn] = raw;
			raw_since[btn] = now;
		end
		held_for = now - raw_since[btn];
		if (held_for < TIME_W'(hold_ms))
			return;
		if (raw == level_held[btn])
			return;
		level_held[btn] = raw;
		ev.event_button = btn;
		if (raw) begin
			press_began[btn] = now;
			ev.action = ACT_PRESS;
			ev.last_event = 1'b1;
			expected_events.push_back(ev);
			return;
		end
		// A stable release is always followed by its length class.
		ev.action = ACT_RELEASE;
		ev.last_event = 1'b0;
		expected_events.push_back(ev);
		pressed_for = now - press_began[btn];
		ev.action = (pressed_for >= TIME_W'(long_ms)) ? ACT_LONG : ACT_SHORT;
		ev.last_event = 1'b1;
		expected_events.push_back(ev);
	endtask

	// ------------------------------------------------------------------------
	// Driver. A new beat is offered whenever the slot is free or the current
	// beat goes through; the idle percentage decides whether a free slot stays
	// empty this cycle. The model is updated on the accepting edge.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		sample_beat_t beat;
		if (!arst_n) begin
			snd_valid <= 1'b0;
		end else begin
			if (snd_valid && sample_ch.ready) begin
				predict_events(snd_btn, snd_raw, snd_stamp);
				outstanding--;
			end
			if (!snd_valid || sample_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
					beat = pending_samples.pop_front();
					snd_valid <= 1'b1;
					snd_btn <= beat.btn;
					snd_raw <= beat.raw;
					snd_stamp <= beat.stamp;
				end else begin
					snd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Every accepted event beat must match the oldest expectation,
	// field by field. Ready is redrawn every cycle from the stall percentage.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (result_ch.valid && rcv_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event beat: button %0d action %0d last %0d",
						result_ch.event_button, result_ch.action, result_ch.last_event);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (result_ch.event_button !== want.event_button) begin
						$error("event_button: expected %0d, got %0d",
							want.event_button, result_ch.event_button);
						mismatches++;
					end
					if (result_ch.action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, result_ch.action);
						mismatches++;
					end
					if (result_ch.last_event !== want.last_event) begin
						$error("last_event: expected %0d, got %0d",
							want.last_event, result_ch.last_event);
						mismatches++;
					end
				end
			end
			rcv_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog. It only counts while some sample or event is still owed, so
	// the deliberate idle pauses between phases never trip it.
	// ------------------------------------------------------------------------
	int unsigned stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n && (outstanding != 0 || expected_events.size() != 0)
			&& !(snd_valid && sample_ch.ready) && !(result_ch.valid && rcv_ready)) begin
			stuck_cycles++;
		end else begin
			stuck_cycles = 0;
		end
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	logic [TIME_W-1:0] t_now;
	logic              intent [NUM_BUTTONS] = '{default: 1'b0};

	task automatic queue_sample(input logic [BTN_W-1:0] btn, input logic raw,
		input logic [TIME_W-1:0] stamp);
		sample_beat_t beat;
		beat.btn = btn;
		beat.raw = raw;
		beat.stamp = stamp;
		pending_samples.push_back(beat);
		outstanding++;
	endtask

	// Waits until every queued sample is in and every expected beat is out,
	// then lets the unit's pipeline settle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (outstanding != 0 || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEBOUNCE)
			hold_ms = value;
		else
			long_ms = value;
	endtask

	// Mostly well-formed presses and releases: an optional bounce burst, then
	// the new level held around and past the debounce window. The lead-in gap
	// is picked so that press lengths often land near the long-press threshold.
	// The rest is random noise and lone glitches that revert.
	task automatic queue_random(input int count);
		int made;
		int unsigned pick;
		int unsigned bounces;
		logic [BTN_W-1:0] b;
		logic lvl;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			b = BTN_W'($urandom_range(NUM_BUTTONS - 1));
			if (pick < 70) begin
				case ($urandom_range(3))
					0: t_now += $urandom_range(hold_ms);
					1: t_now += TIME_W'(hold_ms) + $urandom_range(8);
					2: t_now += TIME_W'(long_ms) + $urandom_range(8) - 4;
					default: t_now += $urandom();
				endcase
				lvl = ~intent[b];
				intent[b] = lvl;
				bounces = $urandom_range(3);
				repeat (bounces) begin
					queue_sample(b, lvl, t_now);
					t_now += $urandom_range(hold_ms / 2);
					queue_sample(b, ~lvl, t_now);
					t_now += $urandom_range(hold_ms / 2);
					made += 2;
				end
				queue_sample(b, lvl, t_now);
				// Land just short of, on, or just past the window edge first.
				t_now += TIME_W'(hold_ms) - 1 + $urandom_range(2);
				queue_sample(b, lvl, t_now);
				t_now += TIME_W'(hold_ms);
				queue_sample(b, lvl, t_now);
				made += 3;
			end else if (pick < 85) begin
				queue_sample(b, 1'($urandom_range(1)), $urandom());
				made++;
			end else begin
				t_now += $urandom_range(hold_ms) + 1;
				queue_sample(b, ~intent[b], t_now);
				t_now += $urandom_range(hold_ms / 2);
				queue_sample(b, intent[b], t_now);
				made += 2;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequencing.
	// ------------------------------------------------------------------------
	initial begin
		t_now = $urandom();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds, no idling on either side.
		// A press whose settle crosses the timestamp wrap, released short.
		queue_sample(3'd0, 1'b1, 32'hFFFF_FFF0);
		queue_sample(3'd0, 1'b1, 32'h0000_0009);
		queue_sample(3'd0, 1'b0, 32'h0000_000E);
		queue_sample(3'd0, 1'b0, 32'h0000_002C);
		// A press held well beyond the threshold.
		queue_sample(3'd1, 1'b1, 32'd100);
		queue_sample(3'd1, 1'b1, 32'd130);
		queue_sample(3'd1, 1'b0, 32'd500);
		queue_sample(3'd1, 1'b0, 32'd530);
		// Both windows met exactly: the debounce settles and the release is long.
		queue_sample(3'd2, 1'b1, 32'd1000);
		queue_sample(3'd2, 1'b1, 32'd1020);
		queue_sample(3'd2, 1'b0, 32'd1300);
		queue_sample(3'd2, 1'b0, 32'd1320);
		// Timestamp extremes on the top button.
		queue_sample(3'd7, 1'b1, 32'h0000_0000);
		queue_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
		queue_sample(3'd7, 1'b0, 32'd5);
		queue_sample(3'd7, 1'b0, 32'd40);
		// Contact bounce that restarts the window before it settles.
		queue_sample(3'd4, 1'b1, 32'd2000);
		queue_sample(3'd4, 1'b0, 32'd2005);
		queue_sample(3'd4, 1'b1, 32'd2010);
		queue_sample(3'd4, 1'b1, 32'd2025);
		queue_sample(3'd4, 1'b1, 32'd2030);
		wait_idle();
		queue_random(150);
		// Hold the sender until the unit has drained completely.
		wait_idle();
		queue_random(150);
		wait_idle();

		// Both thresholds at zero: raw edges are taken at once and every
		// release counts as long. Sender idles.
		write_cfg(CFG_DEBOUNCE, '0);
		write_cfg(CFG_LONG_PRESS, '0);
		idle_pct = 54;
		queue_sample(3'd3, 1'b1, 32'd7000);
		queue_sample(3'd3, 1'b0, 32'd7000);
		queue_random(310);
		wait_idle();

		// Both at their maximum, receiver stalls.
		write_cfg(CFG_DEBOUNCE, CFG_MAX);
		write_cfg(CFG_LONG_PRESS, CFG_MAX);
		idle_pct = 0;
		stall_pct = 54;
		queue_random(310);
		wait_idle();

		// Small thresholds, light pressure on both sides.
		write_cfg(CFG_DEBOUNCE, 16'd5);
		write_cfg(CFG_LONG_PRESS, 16'd50);
		idle_pct = 13;
		stall_pct = 13;
		queue_random(310);
		wait_idle();

		// Slow debounce with every release long, sender idles.
		write_cfg(CFG_DEBOUNCE, CFG_MAX);
		write_cfg(CFG_LONG_PRESS, '0);
		idle_pct = 54;
		stall_pct = 0;
		queue_random(310);
		wait_idle();

		// Instant debounce with the longest threshold, receiver stalls.
		write_cfg(CFG_DEBOUNCE, '0);
		write_cfg(CFG_LONG_PRESS, CFG_MAX);
		idle_pct = 0;
		stall_pct = 54;
		queue_random(310);
		wait_idle();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
